@@ design/log_record_framer_crc8_assert.svh @@
// assertion macros shared by the framer checker
// depends on clk and rst_n being visible where the macros are used
`ifndef LOG_RECORD_FRAMER_CRC8_ASSERT_SVH
`define LOG_RECORD_FRAMER_CRC8_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LFC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer check failed");

// next-cycle implication, disabled during reset
`define LFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

@@ design/lfc_pkg.sv @@
// shared types, constants and functions of the log record framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfc_pkg;

  localparam logic [7:0]  START_MARK   = 8'hAA;
  localparam logic [7:0]  CRC_POLY     = 8'h07;
  localparam int          TABLE_IDS    = 61;
  localparam logic [14:0] THRESH_RESET = 15'd31744;

  localparam logic ACT_LOG   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // byte positions inside a record
  localparam logic [4:0] POS_START = 5'd0;
  localparam logic [4:0] POS_LEN   = 5'd1;
  localparam logic [4:0] POS_ID    = 5'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } lfc_state_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  msg_id;
    logic [63:0] arg_bytes_low;
    logic [47:0] arg_bytes_high;
  } in_word_t;

  typedef struct packed {
    logic        buffer_select;
    logic [14:0] byte_address;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic        full_event;
    logic        full_buffer_select;
    logic        over_threshold;
  } out_word_t;

  // request from the sequencer to the buffer bookkeeping
  typedef struct packed {
    logic       log_en;
    logic       clear_en;
    logic [4:0] nbytes;
  } buf_req_t;

  // buffer state as it stands after the requested record
  typedef struct packed {
    logic sel;
    logic full_sel;
    logic over;
    logic swapped;
  } buf_rsp_t;

  // argument byte count per message id
  function automatic logic [3:0] arg_count(input logic [7:0] id);
    logic [3:0] c;
    c = 4'd0;
    case (id)
      8'd12, 8'd13, 8'd16, 8'd17, 8'd18, 8'd28, 8'd31, 8'd32, 8'd37, 8'd57:
        c = 4'd1;
      8'd8, 8'd14, 8'd20, 8'd22, 8'd24, 8'd26, 8'd45, 8'd58:
        c = 4'd2;
      8'd2, 8'd54, 8'd55, 8'd56, 8'd59:
        c = 4'd3;
      8'd1, 8'd36, 8'd60:
        c = 4'd4;
      8'd9:
        c = 4'd5;
      8'd44, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52:
        c = 4'd6;
      8'd43, 8'd53:
        c = 4'd7;
      8'd30:
        c = 4'd10;
      8'd3:
        c = 4'd14;
      default:
        c = 4'd0;
    endcase
    return c;
  endfunction

  // one crc-8 byte update, msb first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/lfc_crc8.sv @@
// crc-8 accumulator, one byte per cycle while upd is high
// depends on lfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfc_crc8 (
  input  wire logic       clk,
  input  wire logic       clr,
  input  wire logic       upd,
  input  wire logic [7:0] data,
  output logic [7:0]      crc
);
  import lfc_pkg::*;

  logic [7:0] crc_r;
  logic [7:0] crc_nxt;

  // clear at record start, fold one byte per update
  always_comb begin
    crc_nxt = crc_r;
    if (clr) begin
      crc_nxt = 8'h00;
    end else if (upd) begin
      crc_nxt = crc8_byte(crc_r, data);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

`default_nettype wire

@@ design/lfc_buf_ctrl.sv @@
// ping-pong buffer bookkeeping: write indexes, swap and sticky flag
// depends on lfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfc_buf_ctrl #(
  parameter int BUF_BYTES = 32768,
  parameter int IDX_W     = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [14:0]           cfg_wr_data,
  input  wire lfc_pkg::buf_req_t     req,
  output lfc_pkg::buf_rsp_t          rsp,
  output logic [IDX_W-1:0]           start
);
  import lfc_pkg::*;

  localparam int CMP_W = (IDX_W > 15) ? IDX_W : 15;
  localparam logic [IDX_W:0] BUF_LIM = (IDX_W + 1)'(BUF_BYTES);

  logic [14:0]      thresh_r;
  logic             work_sel_r, work_sel_nxt;
  logic             full_sel_r, full_sel_nxt;
  logic             over_r, over_nxt;
  logic [IDX_W-1:0] idx_r [2];
  logic [IDX_W-1:0] idx_nxt [2];
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] next_idx;
  logic             swap;

  // advance the working index with wrap and test against the threshold
  always_comb begin
    start    = idx_r[work_sel_r];
    sum      = {1'b0, start} + (IDX_W + 1)'(req.nbytes);
    next_idx = (sum >= BUF_LIM) ? IDX_W'(sum - BUF_LIM) : IDX_W'(sum);
    swap     = CMP_W'(next_idx) > CMP_W'(thresh_r);
  end

  // state update
  always_comb begin
    work_sel_nxt = work_sel_r;
    full_sel_nxt = full_sel_r;
    over_nxt     = over_r;
    idx_nxt[0]   = idx_r[0];
    idx_nxt[1]   = idx_r[1];
    if (req.clear_en) begin
      over_nxt = 1'b0;
    end else if (req.log_en) begin
      idx_nxt[work_sel_r] = next_idx;
      if (swap) begin
        over_nxt            = 1'b1;
        work_sel_nxt        = ~work_sel_r;
        full_sel_nxt        = work_sel_r;
        idx_nxt[work_sel_r] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= THRESH_RESET;
      work_sel_r <= 1'b0;
      full_sel_r <= 1'b1;
      over_r     <= 1'b0;
      idx_r[0]   <= '0;
      idx_r[1]   <= '0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      work_sel_r <= work_sel_nxt;
      full_sel_r <= full_sel_nxt;
      over_r     <= over_nxt;
      idx_r[0]   <= idx_nxt[0];
      idx_r[1]   <= idx_nxt[1];
    end
  end

  // values seen by every byte of the record being logged
  always_comb begin
    rsp.sel      = work_sel_r;
    rsp.full_sel = full_sel_nxt;
    rsp.over     = over_nxt;
    rsp.swapped  = swap;
  end

endmodule

`default_nettype wire

@@ design/log_record_framer_crc8.sv @@
// Log record framer with CRC-8 and two ping-pong buffers.
// Input channel in_valid/in_ready/in_data takes one event word: a log action
// with message id and argument bytes, or a clear of the over-threshold flag.
// Output channel out_valid/out_ready/out_data gives one byte write per word:
// buffer, address, value and the record flags.
// A logged record of N argument bytes gives N+4 output words, one per cycle
// while out_ready stays high; the first is registered after the state register
// has entered ST_EMIT. in_ready is low from acceptance until the crc byte has
// been loaded into the output register, so one record is emitted at a time; the
// byte sequencer feeds the crc unit one byte per step.
// A clear or an invalid id is taken while idle and gives no output.
// If out_ready is low the output register holds its word and the sequencer
// waits; nothing is dropped.
// cfg_wr_en/cfg_wr_data write the swap threshold; write only while idle.
// Synchronous active-low reset empties the output register, selects buffer 0
// for writing and buffer 1 as full, zeroes both write indexes and the flag,
// and restores the threshold to 31744.
// depends on lfc_pkg, lfc_crc8, lfc_buf_ctrl
`timescale 1ns / 1ps
`default_nettype none

module log_record_framer_crc8 #(
  parameter int BUF_BYTES     = 32768,
  parameter int MSG_IDS       = 61,
  parameter int MAX_ARG_BYTES = 14
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lfc_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lfc_pkg::out_word_t       out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [14:0]         cfg_wr_data
);
  import lfc_pkg::*;

  localparam int IDX_W = $clog2(BUF_BYTES);
  localparam logic [IDX_W-1:0] ADDR_LAST = IDX_W'(BUF_BYTES - 1);

  lfc_state_t       state_r, state_nxt;
  logic             acc;
  logic             id_ok;
  logic [4:0]       cnt;
  buf_req_t         req;
  buf_rsp_t         rsp;
  logic [IDX_W-1:0] start;

  logic [4:0]       pos_r;
  logic [4:0]       nbytes_r;
  logic [7:0]       id_r;
  logic [111:0]     args_r;
  logic [IDX_W-1:0] addr_r;
  logic             sel_r, full_sel_r, over_r, swap_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic             step;
  logic             last_pos;
  logic             arg_pos;
  logic [7:0]       byte_val;
  logic [7:0]       crc;

  // decode the incoming event
  always_comb begin
    acc   = in_valid && in_ready;
    id_ok = (in_data.msg_id != 8'd0) && ({1'b0, in_data.msg_id} < 9'(MSG_IDS))
            && ({1'b0, in_data.msg_id} < 9'(TABLE_IDS));
    cnt   = {1'b0, arg_count(in_data.msg_id)};
    if (cnt > 5'(MAX_ARG_BYTES)) begin
      cnt = 5'(MAX_ARG_BYTES);
    end
    req.log_en   = acc && (in_data.action == ACT_LOG) && id_ok;
    req.clear_en = acc && (in_data.action == ACT_CLEAR);
    req.nbytes   = cnt + 5'd4;
  end

  lfc_buf_ctrl #(
    .BUF_BYTES (BUF_BYTES),
    .IDX_W     (IDX_W)
  ) u_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp),
    .start       (start)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req.log_en) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step && last_pos) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    step     = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EMIT: step = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        step     = 1'b0;
      end
    endcase
  end

  // byte at the current record position
  always_comb begin
    last_pos = (pos_r == nbytes_r - 5'd1);
    arg_pos  = (pos_r > POS_ID) && !last_pos;
    if (last_pos) begin
      byte_val = crc;
    end else begin
      case (pos_r)
        POS_START: byte_val = START_MARK;
        POS_LEN:   byte_val = {3'b000, nbytes_r - 5'd1};
        POS_ID:    byte_val = id_r;
        default:   byte_val = args_r[7:0];
      endcase
    end
  end

  lfc_crc8 u_crc (
    .clk  (clk),
    .clr  (req.log_en),
    .upd  (step && ((pos_r == POS_ID) || arg_pos)),
    .data (byte_val),
    .crc  (crc)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // record context, loaded at acceptance and walked one byte per step
  always_ff @(posedge clk) begin
    if (req.log_en) begin
      pos_r      <= POS_START;
      nbytes_r   <= req.nbytes;
      id_r       <= in_data.msg_id;
      args_r     <= {in_data.arg_bytes_high, in_data.arg_bytes_low};
      addr_r     <= start;
      sel_r      <= rsp.sel;
      full_sel_r <= rsp.full_sel;
      over_r     <= rsp.over;
      swap_r     <= rsp.swapped;
    end else if (step) begin
      pos_r  <= pos_r + 5'd1;
      addr_r <= (addr_r == ADDR_LAST) ? '0 : addr_r + IDX_W'(1);
      if (arg_pos) begin
        args_r <= args_r >> 8;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r.buffer_select      <= sel_r;
      out_data_r.byte_address       <= 15'(addr_r);
      out_data_r.byte_value         <= byte_val;
      out_data_r.last_byte          <= last_pos;
      out_data_r.full_event         <= last_pos && swap_r;
      out_data_r.full_buffer_select <= full_sel_r;
      out_data_r.over_threshold     <= over_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/lfc_checker.sv @@
// port-level checks of the log record framer, bound to the top level
// depends on lfc_pkg, log_record_framer_crc8 and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "log_record_framer_crc8_assert.svh"

module lfc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire lfc_pkg::out_word_t out_data
);
  import lfc_pkg::*;

  // a stalled word holds its value
  `LFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // no new event is taken while a record is still being emitted
  `LFC_ASSERT_IMPL(a_busy, out_valid && !out_data.last_byte, !in_ready)

  // a full event only on the crc byte and with the flag raised
  `LFC_ASSERT_IMPL(a_full_evt, out_valid && out_data.full_event,
                   out_data.last_byte && out_data.over_threshold)

  // bytes of one record follow back to back into the same buffer
  `LFC_ASSERT_NEXT(a_same_buf, out_valid && out_ready && !out_data.last_byte,
                   out_valid && (out_data.buffer_select == $past(out_data.buffer_select)))

endmodule

bind log_record_framer_crc8 lfc_checker u_lfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/sv/log_record_framer_crc8_tb.sv @@
// self-checking bench for log_record_framer_crc8: directed, threshold,
// backpressure and random traffic checked against an in-bench record framer
// depends on lfc_pkg and log_record_framer_crc8
`timescale 1ns / 1ps

module log_record_framer_crc8_tb;
  import lfc_pkg::*;

  localparam int BUF_BYTES   = 32768;
  localparam int NUM_IDS     = 61;
  localparam int MAX_ARGS    = 14;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  // message ids with notable argument counts
  localparam logic [7:0] ID_FIRST    = 8'd1;
  localparam logic [7:0] ID_ARGS_14  = 8'd3;
  localparam logic [7:0] ID_NO_ARGS  = 8'd4;
  localparam logic [7:0] ID_ARGS_5   = 8'd9;
  localparam logic [7:0] ID_ARGS_1   = 8'd12;
  localparam logic [7:0] ID_ARGS_10  = 8'd30;
  localparam logic [7:0] ID_ARGS_7   = 8'd43;
  localparam logic [7:0] ID_LAST     = 8'd60;
  localparam logic [7:0] ID_PAST_END = 8'd61;
  localparam logic [7:0] ID_NONE     = 8'd0;
  localparam logic [7:0] ID_TOP      = 8'd255;

  localparam logic [14:0] THR_MIN = 15'd0;

  // argument byte count per message id
  int arg_len_tbl [0:60] = '{
    0, 4, 3, 14, 0, 0, 0, 0, 2, 5,
    0, 0, 1, 1, 2, 0, 1, 1, 1, 0,
    2, 0, 2, 0, 2, 0, 2, 0, 1, 0,
    10, 1, 1, 0, 0, 0, 4, 1, 0, 0,
    0, 0, 0, 7, 6, 2, 6, 6, 6, 6,
    6, 6, 6, 7, 3, 3, 3, 1, 2, 3,
    4
  };

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  in_word_t   in_data     = '0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  out_word_t  out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [14:0] cfg_wr_data = '0;

  // model of the buffer bookkeeping
  logic        mdl_working;
  logic        mdl_full;
  logic [14:0] mdl_index [2];
  logic        mdl_over;
  logic [14:0] mdl_thresh;

  out_word_t pending_writes [$];
  int        fail_cnt     = 0;
  int        cycle_cnt    = 0;
  int        tx_idle_pct  = 0;
  int        rx_stall_pct = 0;
  int        rx_hold_seq  = 0;
  int        rx_hold_seen = 0;
  int        rx_hold_left = 0;

  log_record_framer_crc8 DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // crc-8, poly 0x07, msb first
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ 8'h07;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // expected byte writes for one accepted word
  task automatic frame_record(in_word_t w);
    logic [7:0]  rec [18];
    logic [7:0]  crc;
    logic [7:0]  arg;
    logic        sel;
    logic        swapped;
    logic [14:0] start;
    int          cnt;
    int          nbytes;
    int          next;
    out_word_t   o;
    if (w.action == ACT_CLEAR) begin
      mdl_over = 1'b0;
      return;
    end
    if (w.msg_id == ID_NONE || w.msg_id >= NUM_IDS) return;
    cnt = arg_len_tbl[w.msg_id];
    if (cnt > MAX_ARGS) cnt = MAX_ARGS;
    rec[0] = START_MARK;
    rec[1] = 8'(cnt + 3);
    rec[2] = w.msg_id;
    crc = crc8_step(8'h00, w.msg_id);
    for (int i = 0; i < cnt; i++) begin
      if (i < 8) arg = w.arg_bytes_low[8*i +: 8];
      else arg = w.arg_bytes_high[8*(i-8) +: 8];
      rec[3+i] = arg;
      crc = crc8_step(crc, arg);
    end
    rec[3+cnt] = crc;
    nbytes = cnt + 4;
    // advance the working buffer and swap when past the threshold
    sel = mdl_working;
    start = mdl_index[sel];
    next = (int'(start) + nbytes) % BUF_BYTES;
    mdl_index[sel] = 15'(next);
    swapped = 1'b0;
    if (next > int'(mdl_thresh)) begin
      mdl_over = 1'b1;
      mdl_working = ~sel;
      mdl_full = sel;
      mdl_index[sel] = '0;
      swapped = 1'b1;
    end
    for (int i = 0; i < nbytes; i++) begin
      o.buffer_select      = sel;
      o.byte_address       = 15'((int'(start) + i) % BUF_BYTES);
      o.byte_value         = rec[i];
      o.last_byte          = (i == nbytes - 1);
      o.full_event         = (i == nbytes - 1) && swapped;
      o.full_buffer_select = mdl_full;
      o.over_threshold     = mdl_over;
      pending_writes.push_back(o);
    end
  endtask

  // model update on register writes and accepted words
  always @(posedge clk) begin
    if (!rst_n) begin
      mdl_working  = 1'b0;
      mdl_full     = 1'b1;
      mdl_index[0] = '0;
      mdl_index[1] = '0;
      mdl_over     = 1'b0;
      mdl_thresh   = THRESH_RESET;
    end else begin
      if (cfg_wr_en) mdl_thresh = cfg_wr_data;
      if (in_valid && in_ready) frame_record(in_data);
    end
  end

  // compare one byte write with the oldest expected one
  task automatic check_write(out_word_t got);
    out_word_t want;
    logic      bad;
    if (pending_writes.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("unexpected byte write: buf=%0d addr=%0d val=%02h",
                 got.buffer_select, got.byte_address, got.byte_value);
      return;
    end
    want = pending_writes.pop_front();
    bad = (got.buffer_select !== want.buffer_select) ||
          (got.byte_address !== want.byte_address) ||
          (got.byte_value !== want.byte_value) ||
          (got.last_byte !== want.last_byte) ||
          (got.full_event !== want.full_event) ||
          (got.full_buffer_select !== want.full_buffer_select) ||
          (got.over_threshold !== want.over_threshold);
    if (bad) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("byte write mismatch at cycle %0d", cycle_cnt);
        $display("  expected buf=%0d addr=%0d val=%02h last=%0b full=%0b fbuf=%0b over=%0b",
                 want.buffer_select, want.byte_address, want.byte_value, want.last_byte,
                 want.full_event, want.full_buffer_select, want.over_threshold);
        $display("  actual   buf=%0d addr=%0d val=%02h last=%0b full=%0b fbuf=%0b over=%0b",
                 got.buffer_select, got.byte_address, got.byte_value, got.last_byte,
                 got.full_event, got.full_buffer_select, got.over_threshold);
      end
    end
  endtask

  // result word monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_write(out_data);
  end

  // result side: random stalls plus an on-demand long hold-off
  always @(posedge clk) begin
    if (rx_hold_seq != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_seq;
      rx_hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // offer one word and wait for it to be taken, then maybe go idle
  task automatic put_word(in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop offering and let every expected write come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_swap_threshold(logic [14:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic in_word_t log_word(logic [7:0] id, logic [63:0] lo, logic [47:0] hi);
    in_word_t w;
    w.action = ACT_LOG;
    w.msg_id = id;
    w.arg_bytes_low = lo;
    w.arg_bytes_high = hi;
    return w;
  endfunction

  function automatic in_word_t clear_word(logic [7:0] id, logic [63:0] lo, logic [47:0] hi);
    in_word_t w;
    w = log_word(id, lo, hi);
    w.action = ACT_CLEAR;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = rand64();
    return r[47:0];
  endfunction

  // random word: mostly valid records, some clears and bad ids
  function automatic in_word_t rand_word();
    int pick;
    logic [7:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 8) return clear_word(8'($urandom()), rand64(), rand48());
    if (pick < 16) begin
      id = ($urandom_range(0, 3) == 0) ? ID_NONE : 8'($urandom_range(NUM_IDS, 255));
      return log_word(id, rand64(), rand48());
    end
    return log_word(8'($urandom_range(1, NUM_IDS - 1)), rand64(), rand48());
  endfunction

  function automatic logic is_record(in_word_t w);
    return (w.action == ACT_LOG) && (w.msg_id != ID_NONE) && (w.msg_id < NUM_IDS);
  endfunction

  // field extremes, bad ids, clears and a spread of argument counts
  task automatic test_directed();
    logic [63:0] ones_lo;
    logic [47:0] ones_hi;
    logic [63:0] pat_lo;
    logic [47:0] pat_hi;
    ones_lo = '1;
    ones_hi = '1;
    pat_lo = 64'h0807_0605_0403_0201;
    pat_hi = 48'h0E0D_0C0B_0A09;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    put_word(log_word(ID_NONE, ones_lo, ones_hi));
    put_word(log_word(ID_PAST_END, pat_lo, pat_hi));
    put_word(log_word(ID_TOP, ones_lo, ones_hi));
    put_word(clear_word(ID_ARGS_14, ones_lo, ones_hi));
    put_word(log_word(ID_ARGS_14, ones_lo, ones_hi));
    put_word(log_word(ID_ARGS_14, '0, '0));
    put_word(log_word(ID_ARGS_14, pat_lo, pat_hi));
    put_word(log_word(ID_NO_ARGS, ones_lo, ones_hi));
    put_word(log_word(ID_FIRST, pat_lo, pat_hi));
    put_word(log_word(ID_LAST, pat_lo, pat_hi));
    put_word(log_word(ID_ARGS_10, ones_lo, ones_hi));
    put_word(log_word(ID_ARGS_7, 64'h5A5A_A5A5_5A5A_A5A5, ones_hi));
    put_word(log_word(ID_ARGS_5, 64'h8000_0000_0000_0080, 48'h8000_0000_0001));
    put_word(log_word(ID_ARGS_1, '0, '0));
    put_word(clear_word(ID_TOP, '0, '0));
    put_word(log_word(ID_ARGS_1, ones_lo, ones_hi));
    settle();
  endtask

  // swap exactly past the threshold, not at it
  task automatic test_swap_threshold();
    // two swaps at threshold zero leave both write indexes at zero
    set_swap_threshold(THR_MIN);
    put_word(log_word(ID_NO_ARGS, rand64(), rand48()));
    put_word(log_word(ID_NO_ARGS, rand64(), rand48()));
    settle();
    set_swap_threshold(15'd18);
    put_word(log_word(ID_ARGS_14, rand64(), rand48()));
    put_word(log_word(ID_NO_ARGS, rand64(), rand48()));
    settle();
    set_swap_threshold(15'd17);
    put_word(log_word(ID_ARGS_14, rand64(), rand48()));
    put_word(clear_word(ID_ARGS_14, rand64(), rand48()));
    put_word(log_word(ID_NO_ARGS, rand64(), rand48()));
    settle();
  endtask

  // random phases under each idling pattern
  task automatic run_traffic(int n_recs, int tx_pct, int rx_pct, logic [14:0] thr);
    in_word_t w;
    int done;
    settle();
    set_swap_threshold(thr);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    done = 0;
    while (done < n_recs) begin
      w = rand_word();
      put_word(w);
      if (is_record(w)) done++;
    end
    settle();
  endtask

  task automatic test_random_traffic();
    run_traffic(65, 0, 0, 15'($urandom_range(0, 400)));
    run_traffic(65, 77, 0, 15'($urandom_range(0, 400)));
    run_traffic(65, 0, 77, 15'($urandom_range(0, 32767)));
    run_traffic(65, 38, 38, 15'($urandom_range(0, 400)));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  // long result hold-off with the input kept busy, then a full drain
  task automatic test_backpressure();
    in_word_t w;
    int done;
    settle();
    set_swap_threshold(15'($urandom_range(100, 300)));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_seq <= rx_hold_seq + 1;
    done = 0;
    while (done < 12) begin
      w = rand_word();
      put_word(w);
      if (is_record(w)) done++;
    end
    settle();
    for (int i = 0; i < 6; i++) put_word(rand_word());
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_swap_threshold();
    test_random_traffic();
    test_backpressure();
    settle();
    if (fail_cnt == 0 && pending_writes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/lfc_pkg.sv
design/lfc_crc8.sv
design/lfc_buf_ctrl.sv
design/log_record_framer_crc8.sv
design/lfc_checker.sv
tb/sv/log_record_framer_crc8_tb.sv
